### rtl/blsp_pkg.sv
// ----------------------------------------------------------------------------
// blsp_pkg - shared types and constants for the Bresenham line stepper
// Coordinate width, packed stream layouts and command codes.
// ----------------------------------------------------------------------------
package blsp_pkg;

    // Coordinate width and derived widths
    localparam int COORD_BITS  = 12;
    localparam int COLOUR_BITS = 32;
    localparam int SPAN_BITS   = COORD_BITS + 2;   // twice an absolute span
    localparam int ERR_BITS    = COORD_BITS + 3;   // signed error term

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOUR_BITS;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOUR_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Command codes carried in s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic [SPAN_BITS-1:0]      span_t;
    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic [COLOUR_BITS-1:0]    colour_t;

    // Input item, x_start in the lowest bits
    typedef struct packed {
        colour_t colour_in;
        coord_t  y_end;
        coord_t  x_end;
        coord_t  y_start;
        coord_t  x_start;
    } in_item_t;

    // Result item, pixel_x in the lowest bits
    typedef struct packed {
        colour_t pixel_colour;
        coord_t  pixel_y;
        coord_t  pixel_x;
    } out_item_t;

endpackage

### rtl/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper - integer Bresenham line walker
// Loads a line and emits its first pixel on a load command, then one per step.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                        Contents
//  s_       in   s_tvalid/s_tready/s_tdata/     x_start, y_start, x_end, y_end,
//                s_tuser                        colour_in; tuser = command
//  m_       out  m_tvalid/m_tready/m_tdata/     pixel_x, pixel_y, pixel_colour;
//                m_tlast                        tlast = line_done
//
//  One item per clock while m_tready allows: each accepted transfer updates
//  the line state and loads the result register in the same cycle.
//  s_tready is high while the result register is empty or being drained.
//  A step with no active line is accepted and produces no transfer.
//  aresetn (synchronous) drops any active line and empties the output.
// ----------------------------------------------------------------------------
module bresenham_line_stepper (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_start, y_start, x_end, y_end, colour_in (low bits up), zero padded
    input  logic [blsp_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x, pixel_y, pixel_colour (low bits up), zero padded
    output logic [blsp_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic                                m_tlast
);
    import blsp_pkg::*;

    // Line state
    coord_t    cur_x_reg, cur_x_next;
    coord_t    cur_y_reg, cur_y_next;
    coord_t    target_x_reg, target_x_next;
    coord_t    target_y_reg, target_y_next;
    err_t      err_term_reg, err_term_next;
    span_t     twice_dx_reg, twice_dx_next;
    span_t     twice_dy_reg, twice_dy_next;
    logic      x_negative_reg, x_negative_next;
    logic      y_negative_reg, y_negative_next;
    logic      x_major_reg, x_major_next;
    colour_t   line_colour_reg, line_colour_next;
    logic      line_active_reg, line_active_next;

    // Result register
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      out_last_reg;

    in_item_t  in_item;
    logic      s_fire;
    logic      emit;
    logic      done;

    // Load-path intermediates
    logic signed [COORD_BITS:0] dx, dy;
    coord_t    abs_dx, abs_dy;
    span_t     ld_twice_dx, ld_twice_dy;
    logic      ld_x_major;

    // Step-path intermediates
    err_t      err_adj;
    logic      minor_step;
    coord_t    major_cur, major_tgt;
    logic [COORD_BITS:0] major_diff;

    assign in_item  = in_item_t'(s_tdata[IN_FIELD_BITS-1:0]);
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Spans of a new line
    always_comb begin
        dx = $signed({1'b0, in_item.x_end}) - $signed({1'b0, in_item.x_start});
        dy = $signed({1'b0, in_item.y_end}) - $signed({1'b0, in_item.y_start});
        abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        ld_twice_dx = {SPAN_BITS'(abs_dx)} << 1;
        ld_twice_dy = {SPAN_BITS'(abs_dy)} << 1;
        ld_x_major  = ld_twice_dx > ld_twice_dy;
    end

    // Next line state
    always_comb begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        err_term_next    = err_term_reg;
        twice_dx_next    = twice_dx_reg;
        twice_dy_next    = twice_dy_reg;
        x_negative_next  = x_negative_reg;
        y_negative_next  = y_negative_reg;
        x_major_next     = x_major_reg;
        line_colour_next = line_colour_reg;
        emit             = 1'b0;
        minor_step       = !err_term_reg[ERR_BITS-1];
        err_adj          = err_term_reg;

        if (s_tuser == CMD_LOAD) begin
            emit             = 1'b1;
            cur_x_next       = in_item.x_start;
            cur_y_next       = in_item.y_start;
            target_x_next    = in_item.x_end;
            target_y_next    = in_item.y_end;
            twice_dx_next    = ld_twice_dx;
            twice_dy_next    = ld_twice_dy;
            x_negative_next  = dx[COORD_BITS];
            y_negative_next  = dy[COORD_BITS];
            x_major_next     = ld_x_major;
            line_colour_next = in_item.colour_in;
            err_term_next    = ld_x_major
                ? $signed(ERR_BITS'(ld_twice_dy)) - $signed(ERR_BITS'(abs_dx))
                : $signed(ERR_BITS'(ld_twice_dx)) - $signed(ERR_BITS'(abs_dy));
        end else if (line_active_reg) begin
            emit = 1'b1;
            // minor axis moves when the error is non-negative
            if (x_major_reg) begin
                if (minor_step) begin
                    cur_y_next = y_negative_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                    err_adj    = err_term_reg - $signed(ERR_BITS'(twice_dx_reg));
                end
                cur_x_next    = x_negative_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                err_term_next = err_adj + $signed(ERR_BITS'(twice_dy_reg));
            end else begin
                if (minor_step) begin
                    cur_x_next = x_negative_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                    err_adj    = err_term_reg - $signed(ERR_BITS'(twice_dy_reg));
                end
                cur_y_next    = y_negative_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                err_term_next = err_adj + $signed(ERR_BITS'(twice_dx_reg));
            end
        end

        // Done when the major coordinate is within one of its target
        major_cur  = x_major_next ? cur_x_next : cur_y_next;
        major_tgt  = x_major_next ? target_x_next : target_y_next;
        major_diff = {1'b0, major_cur} - {1'b0, major_tgt};
        done       = (major_diff == '0) || (major_diff == (COORD_BITS+1)'(1))
                     || (major_diff == '1);
        line_active_next = emit ? !done : line_active_reg;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            err_term_reg    <= '0;
            twice_dx_reg    <= '0;
            twice_dy_reg    <= '0;
            x_negative_reg  <= 1'b0;
            y_negative_reg  <= 1'b0;
            x_major_reg     <= 1'b0;
            line_colour_reg <= '0;
            line_active_reg <= 1'b0;
        end else if (s_fire) begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            err_term_reg    <= err_term_next;
            twice_dx_reg    <= twice_dx_next;
            twice_dy_reg    <= twice_dy_next;
            x_negative_reg  <= x_negative_next;
            y_negative_reg  <= y_negative_next;
            x_major_reg     <= x_major_next;
            line_colour_reg <= line_colour_next;
            line_active_reg <= line_active_next;
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_fire) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            out_item_reg.pixel_x      <= cur_x_next;
            out_item_reg.pixel_y      <= cur_y_next;
            out_item_reg.pixel_colour <= line_colour_next;
            out_last_reg              <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'(out_item_reg);
    assign m_tlast  = out_last_reg;

    // A step with no active line leaves the walk untouched
    a_idle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == CMD_STEP && !line_active_reg)
        |=> (!line_active_reg && !m_tvalid && $stable(cur_x_reg) && $stable(cur_y_reg)))
        else $error("idle step changed line state or emitted a pixel");

    // Every load yields a pixel on the next cycle
    a_load_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == CMD_LOAD) |=> m_tvalid)
        else $error("load did not produce a pixel");

    // The last pixel of a line ends the walk
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && emit && done) |=> (m_tlast && !line_active_reg))
        else $error("line still active after its last pixel");

    // A line only becomes active through a load
    a_active_by_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(line_active_reg) |-> $past(s_fire && s_tuser == CMD_LOAD))
        else $error("line became active without a load");

endmodule
